// ===== hw/rtl/kcl_pkg.sv =====
package kcl_pkg;

   // field widths
   localparam int OP_W     = 2;
   localparam int DIGIT_W  = 3;
   localparam int MODE_W   = 2;
   localparam int EV_W     = 3;
   localparam int TIME_W   = 16;
   localparam int TIMER_W  = 17;

   localparam int CODE_DIGITS_DEFAULT = 4;

   typedef logic [OP_W-1:0]    op_type;
   typedef logic [DIGIT_W-1:0] digit_type;
   typedef logic [MODE_W-1:0]  mode_type;
   typedef logic [EV_W-1:0]    event_type;
   typedef logic [TIME_W-1:0]  time_type;
   typedef logic [TIMER_W-1:0] timer_type;

   // operation codes
   localparam op_type OP_TICK   = 2'd0;
   localparam op_type OP_DIGIT  = 2'd1;
   localparam op_type OP_CHANGE = 2'd2;

   // lock modes
   localparam mode_type MODE_LOCKED   = 2'd0;
   localparam mode_type MODE_UNLOCKED = 2'd1;
   localparam mode_type MODE_CHANGE   = 2'd2;

   // reported events
   localparam event_type EV_NONE     = 3'd0;
   localparam event_type EV_UNLOCKED = 3'd1;
   localparam event_type EV_TIMEOUT  = 3'd2;
   localparam event_type EV_CHANGED  = 3'd3;
   localparam event_type EV_MISMATCH = 3'd4;

   // accepted key range
   localparam digit_type DIGIT_MIN = 3'd1;
   localparam digit_type DIGIT_MAX = 3'd4;

   localparam time_type RELOCK_LIMIT_RESET = 16'd5000;

   // factory code, repeated for longer codes
   localparam int FACTORY_LEN = 4;
   localparam digit_type SHIPPED_CODE [FACTORY_LEN] = '{3'd1, 3'd2, 3'd3, 3'd4};

   typedef struct packed {
      op_type    operation;
      digit_type digit;
   } item_type;

   typedef struct packed {
      mode_type  mode;
      logic      bolt_open;
      event_type event_res;
   } result_type;

endpackage

// ===== hw/rtl/kcl_req_if.sv =====
interface kcl_req_if;
   import kcl_pkg::*;

   logic      valid;
   logic      ready;
   op_type    operation;
   digit_type digit;

   modport source (output valid, output operation, output digit, input ready);
   modport sink   (input valid, input operation, input digit, output ready);

endinterface

// ===== hw/rtl/kcl_rsp_if.sv =====
interface kcl_rsp_if;
   import kcl_pkg::*;

   logic      valid;
   logic      ready;
   mode_type  mode;
   logic      bolt_open;
   event_type event_res;

   modport source (output valid, output mode, output bolt_open, output event_res,
                   input ready);
   modport sink   (input valid, input mode, input bolt_open, input event_res,
                   output ready);

endinterface

// ===== hw/rtl/kcl_req_stage.sv =====
module kcl_req_stage (
   input  logic              clock,
   input  logic              reset,
   kcl_req_if.sink           req,
   input  logic              take,
   output logic              valid,
   output kcl_pkg::item_type item
);
   import kcl_pkg::*;

   logic     valid_ff, valid_in;
   item_type item_ff;

   // room when empty or when the held item moves on this cycle
   assign req.ready = !valid_ff || take;

   always_comb begin
      valid_in = valid_ff;
      if (req.valid && req.ready) begin
         valid_in = 1'b1;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         item_ff.operation <= req.operation;
         item_ff.digit     <= req.digit;
      end
   end

   assign valid = valid_ff;
   assign item  = item_ff;

endmodule

// ===== hw/rtl/kcl_lock_engine.sv =====
module kcl_lock_engine #(
   parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  kcl_pkg::item_type   item,
   input  kcl_pkg::time_type   relock_limit,
   output kcl_pkg::result_type result
);
   import kcl_pkg::*;

   localparam int CNT_W = (CODE_DIGITS > 1) ? $clog2(CODE_DIGITS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_DIGITS - 1);

   typedef digit_type [CODE_DIGITS-1:0] code_type;

   mode_type         mode_ff, mode_in;
   code_type         window_ff, window_in;
   code_type         code_ff, code_in;
   code_type         first_ff, first_in;
   code_type         second_ff, second_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             second_pass_ff, second_pass_in;
   logic             change_ff, change_in;
   timer_type        timer_ff, timer_in;

   code_type  window_sh, first_sh, second_sh;
   timer_type timer_inc;
   logic      dig_ok;
   event_type ev;

   assign dig_ok = (item.operation == OP_DIGIT) &&
                   (item.digit >= DIGIT_MIN) && (item.digit <= DIGIT_MAX);

   // shift the new key in at the top, oldest digit drops out at index 0
   always_comb begin
      for (int i = 0; i < CODE_DIGITS - 1; i++) begin
         window_sh[i] = window_ff[i+1];
         first_sh[i]  = first_ff[i+1];
         second_sh[i] = second_ff[i+1];
      end
      window_sh[CODE_DIGITS-1] = item.digit;
      first_sh[CODE_DIGITS-1]  = item.digit;
      second_sh[CODE_DIGITS-1] = item.digit;
   end

   // saturating relock timer
   assign timer_inc = (timer_ff == '1) ? timer_ff : timer_ff + TIMER_W'(1);

   // next state for one item
   always_comb begin
      mode_in        = mode_ff;
      window_in      = window_ff;
      code_in        = code_ff;
      first_in       = first_ff;
      second_in      = second_ff;
      count_in       = count_ff;
      second_pass_in = second_pass_ff;
      change_in      = change_ff;
      timer_in       = timer_ff;
      ev             = EV_NONE;

      if (item.operation == OP_CHANGE) begin
         change_in = 1'b1;
      end

      unique case (mode_ff)
         MODE_LOCKED: begin
            if (dig_ok) begin
               window_in = window_sh;
               if (window_sh == code_ff) begin
                  mode_in   = MODE_UNLOCKED;
                  window_in = '0;
                  timer_in  = '0;
                  ev        = EV_UNLOCKED;
               end
            end
         end
         MODE_UNLOCKED: begin
            if (item.operation == OP_TICK) begin
               timer_in = timer_inc;
               if (timer_inc > {1'b0, relock_limit}) begin
                  mode_in  = MODE_LOCKED;
                  timer_in = '0;
                  ev       = EV_TIMEOUT;
               end
            end
         end
         MODE_CHANGE: begin
            if (dig_ok) begin
               if (!second_pass_ff) begin
                  first_in = first_sh;
                  if (count_ff == CNT_LAST) begin
                     count_in       = '0;
                     second_pass_in = 1'b1;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end else begin
                  second_in = second_sh;
                  if (count_ff == CNT_LAST) begin
                     // second entry complete: store on match, relock either way
                     if (second_sh == first_ff) begin
                        code_in = first_ff;
                        ev      = EV_CHANGED;
                     end else begin
                        ev      = EV_MISMATCH;
                     end
                     mode_in        = MODE_LOCKED;
                     change_in      = 1'b0;
                     second_pass_in = 1'b0;
                     count_in       = '0;
                     timer_in       = '0;
                     window_in      = '0;
                  end else begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end
            end
         end
         default: ;
      endcase

      // pending change request takes over an unlocked lock
      if ((mode_in == MODE_UNLOCKED) && change_in) begin
         mode_in        = MODE_CHANGE;
         timer_in       = '0;
         count_in       = '0;
         second_pass_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= MODE_LOCKED;
         window_ff      <= '0;
         first_ff       <= '0;
         second_ff      <= '0;
         count_ff       <= '0;
         second_pass_ff <= 1'b0;
         change_ff      <= 1'b0;
         timer_ff       <= '0;
         for (int i = 0; i < CODE_DIGITS; i++) begin
            code_ff[i] <= SHIPPED_CODE[2'(i)];
         end
      end else if (step) begin
         mode_ff        <= mode_in;
         window_ff      <= window_in;
         code_ff        <= code_in;
         first_ff       <= first_in;
         second_ff      <= second_in;
         count_ff       <= count_in;
         second_pass_ff <= second_pass_in;
         change_ff      <= change_in;
         timer_ff       <= timer_in;
      end
   end

   assign result.mode      = mode_in;
   assign result.bolt_open = (mode_in != MODE_LOCKED);
   assign result.event_res = ev;

endmodule

// ===== hw/rtl/keypad_combination_lock_fsm_core.sv =====
// Keypad combination lock controller.
// req_chan carries one item per key event: a 1 ms tick, a digit key press
// (digit 1..4) or a change-code key press. rsp_chan returns exactly one item
// per request: the lock mode after the event, the bolt drive and an event
// code (unlocked, timeout relock, code changed, change mismatch).
// csr_we/csr_wdata write the relock limit, the number of ticks the bolt stays
// open; write it only while no request is in flight.
// A request accepted on req_chan is captured in the input register; the
// state update runs combinationally from that register and the result
// register loads when the item moves on, which needs rsp_chan free or
// draining. Throughput is one item per cycle while rsp_chan does not stall,
// set by the combinational update between the input and result registers.
// Reset (synchronous, active high) empties both registers, locks the bolt,
// clears the entry window and timer, restores the factory code 1,2,3,4 and
// sets the relock limit to 5000.
// When rsp_chan stalls, the result register holds its item and the input
// register keeps one more; req_chan.ready drops once both are full.
module keypad_combination_lock_fsm_core #(
   parameter int CODE_DIGITS = kcl_pkg::CODE_DIGITS_DEFAULT
) (
   input  logic              clock,
   input  logic              reset,
   kcl_req_if.sink           req_chan,
   kcl_rsp_if.source         rsp_chan,
   input  logic              csr_we,
   input  kcl_pkg::time_type csr_wdata
);
   import kcl_pkg::*;

   logic       stage_valid;
   item_type   stage_item;
   logic       take;
   result_type result;

   time_type   relock_limit_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;

   // input register moves on when the result register is free or draining
   assign take = stage_valid && (!rsp_valid_ff || rsp_chan.ready);

   kcl_req_stage u_req_stage (
      .clock (clock),
      .reset (reset),
      .req   (req_chan),
      .take  (take),
      .valid (stage_valid),
      .item  (stage_item)
   );

   kcl_lock_engine #(
      .CODE_DIGITS (CODE_DIGITS)
   ) u_lock_engine (
      .clock        (clock),
      .reset        (reset),
      .step         (take),
      .item         (stage_item),
      .relock_limit (relock_limit_ff),
      .result       (result)
   );

   // relock limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         relock_limit_ff <= RELOCK_LIMIT_RESET;
      end else if (csr_we) begin
         relock_limit_ff <= csr_wdata;
      end
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.mode      = rsp_data_ff.mode;
   assign rsp_chan.bolt_open = rsp_data_ff.bolt_open;
   assign rsp_chan.event_res = rsp_data_ff.event_res;

endmodule

// ===== tb/sv/kcl_lock_monitor.sv =====
// Watches both channels and the relock limit write port. It keeps its own copy
// of the lock state, predicts the result item for every accepted key item and
// compares each delivered result with the oldest prediction.
module kcl_lock_monitor
   import kcl_pkg::*;
#(
   parameter int CODE_DIGITS = CODE_DIGITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   kcl_req_if                          req_chan,
   kcl_rsp_if                          rsp_chan,
   input  logic                        csr_we,
   input  time_type                    csr_wdata,
   output int                          fail_count,
   output int                          pending,
   output mode_type                    mode_now,
   output logic                        change_armed,
   output digit_type [CODE_DIGITS-1:0] code_now,
   output int                          result_count,
   output int                          unlock_count,
   output int                          relock_count,
   output int                          changed_count,
   output int                          mismatch_count
);

   localparam int PRINT_LIMIT = 40;

   // shadow lock state; index 0 holds the oldest digit of a sequence
   mode_type                    lock_mode;
   digit_type [CODE_DIGITS-1:0] window;
   digit_type [CODE_DIGITS-1:0] code;
   digit_type [CODE_DIGITS-1:0] first_code;
   digit_type [CODE_DIGITS-1:0] second_code;
   int                          key_count;
   logic                        second_pass;
   logic                        change_pending;
   timer_type                   open_ticks;
   time_type                    relock_limit;

   // results owed by the block, oldest first
   result_type lock_outcomes[$];

   task automatic report_mismatch(string field, int got, int want);
      fail_count++;
      if (fail_count <= PRINT_LIMIT)
         $display("%0t: result %0d %s: got %0d, expected %0d",
                  $realtime, result_count, field, got, want);
   endtask

   // one key item applied to the shadow state
   function automatic result_type advance_lock(op_type op, digit_type d);
      logic       key_ok;
      event_type  ev;
      result_type res;
      key_ok = (op == OP_DIGIT) && (d >= DIGIT_MIN) && (d <= DIGIT_MAX);
      ev     = EV_NONE;
      if (op == OP_CHANGE)
         change_pending = 1'b1;
      case (lock_mode)
         MODE_LOCKED: begin
            if (key_ok) begin
               window = {d, window[CODE_DIGITS-1:1]};
               if (window == code) begin
                  lock_mode  = MODE_UNLOCKED;
                  window     = '0;
                  open_ticks = '0;
                  ev         = EV_UNLOCKED;
               end
            end
         end
         MODE_UNLOCKED: begin
            if (op == OP_TICK) begin
               if (open_ticks != '1)
                  open_ticks = open_ticks + 1'b1;
               if (open_ticks > timer_type'(relock_limit)) begin
                  lock_mode  = MODE_LOCKED;
                  open_ticks = '0;
                  ev         = EV_TIMEOUT;
               end
            end
         end
         default: begin
            // code change: two entries of the new code
            if (key_ok) begin
               if (!second_pass) begin
                  first_code = {d, first_code[CODE_DIGITS-1:1]};
                  key_count++;
                  if (key_count >= CODE_DIGITS) begin
                     key_count   = 0;
                     second_pass = 1'b1;
                  end
               end else begin
                  second_code = {d, second_code[CODE_DIGITS-1:1]};
                  key_count++;
                  if (key_count >= CODE_DIGITS) begin
                     if (first_code == second_code) begin
                        code = first_code;
                        ev   = EV_CHANGED;
                     end else begin
                        ev = EV_MISMATCH;
                     end
                     lock_mode      = MODE_LOCKED;
                     change_pending = 1'b0;
                     second_pass    = 1'b0;
                     key_count      = 0;
                     open_ticks     = '0;
                     window         = '0;
                  end
               end
            end
         end
      endcase
      // a latched change request takes over as soon as the lock is open
      if (lock_mode == MODE_UNLOCKED && change_pending) begin
         lock_mode   = MODE_CHANGE;
         open_ticks  = '0;
         key_count   = 0;
         second_pass = 1'b0;
      end
      res.mode      = lock_mode;
      res.bolt_open = (lock_mode != MODE_LOCKED);
      res.event_res = ev;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      result_type want;
      result_type next_res;
      if (reset) begin
         lock_mode      = MODE_LOCKED;
         window         = '0;
         first_code     = '0;
         second_code    = '0;
         key_count      = 0;
         second_pass    = 1'b0;
         change_pending = 1'b0;
         open_ticks     = '0;
         relock_limit   = RELOCK_LIMIT_RESET;
         for (int i = 0; i < CODE_DIGITS; i++)
            code[i] = SHIPPED_CODE[2'(i % FACTORY_LEN)];
         lock_outcomes.delete();
         fail_count     = 0;
         result_count   = 0;
         unlock_count   = 0;
         relock_count   = 0;
         changed_count  = 0;
         mismatch_count = 0;
      end else begin
         // results first: a result never belongs to an item taken at the same edge
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (lock_outcomes.size() == 0) begin
               report_mismatch("arrived with nothing outstanding", rsp_chan.event_res, -1);
            end else begin
               want = lock_outcomes.pop_front();
               if (rsp_chan.mode !== want.mode)
                  report_mismatch("mode", rsp_chan.mode, want.mode);
               if (rsp_chan.bolt_open !== want.bolt_open)
                  report_mismatch("bolt_open", rsp_chan.bolt_open, want.bolt_open);
               if (rsp_chan.event_res !== want.event_res)
                  report_mismatch("event_res", rsp_chan.event_res, want.event_res);
            end
            result_count++;
         end
         if (req_chan.valid && req_chan.ready) begin
            next_res = advance_lock(req_chan.operation, req_chan.digit);
            lock_outcomes.push_back(next_res);
            case (next_res.event_res)
               EV_UNLOCKED: unlock_count++;
               EV_TIMEOUT:  relock_count++;
               EV_CHANGED:  changed_count++;
               EV_MISMATCH: mismatch_count++;
               default: ;
            endcase
         end
         if (csr_we)
            relock_limit = csr_wdata;
      end
      // state seen by the stimulus, registered from the shadow state after each update
      mode_now     <= lock_mode;
      code_now     <= code;
      change_armed <= change_pending;
      pending      <= lock_outcomes.size();
   end

endmodule

// ===== tb/sv/tb_keypad_combination_lock_fsm_core.sv =====
module tb_keypad_combination_lock_fsm_core;
   import kcl_pkg::*;

   localparam int     CODE_DIGITS    = CODE_DIGITS_DEFAULT;
   localparam op_type OP_UNDEFINED   = 2'd3;
   localparam int     WATCHDOG_LIMIT = 4000;
   localparam int     TAIL_CYCLES    = 20;
   localparam int     SEGMENT_ITEMS  = 242;
   localparam time_type SEGMENT_RELOCK_LIMIT [6] =
      '{16'd3, 16'd0, 16'hFFFF, 16'd1, 16'd9, 16'd12};

   logic     clock = 1'b0;
   logic     reset = 1'b1;
   logic     csr_we;
   time_type csr_wdata;

   kcl_req_if req_chan();
   kcl_rsp_if rsp_chan();

   int       send_idle;
   int       recv_idle;
   int       planned_items = 0;
   time_type relock_limit_set;
   int       quiet_cycles = 0;

   int                          fail_count;
   int                          pending;
   mode_type                    mode_now;
   logic                        change_armed;
   digit_type [CODE_DIGITS-1:0] code_now;
   int                          result_count;
   int                          unlock_count;
   int                          relock_count;
   int                          changed_count;
   int                          mismatch_count;

   keypad_combination_lock_fsm_core #(
      .CODE_DIGITS(CODE_DIGITS)
   ) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_we   (csr_we),
      .csr_wdata(csr_wdata)
   );

   kcl_lock_monitor #(
      .CODE_DIGITS(CODE_DIGITS)
   ) lock_monitor (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .csr_we        (csr_we),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending),
      .mode_now      (mode_now),
      .change_armed  (change_armed),
      .code_now      (code_now),
      .result_count  (result_count),
      .unlock_count  (unlock_count),
      .relock_count  (relock_count),
      .changed_count (changed_count),
      .mismatch_count(mismatch_count)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // result side stalls at random
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle);
   end

   // ends a run that stops moving
   always @(posedge clock) begin
      if (reset || csr_we || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("timeout: nothing accepted for %0d cycles", quiet_cycles);
         $display("** keypad_combination_lock_fsm_core: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic digit_type rand_key();
      return digit_type'($urandom_range(DIGIT_MIN, DIGIT_MAX));
   endfunction

   // offer one item, holding it until it is taken
   task automatic send_key(op_type op, digit_type d);
      while ($urandom_range(0, 99) < send_idle) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.digit     <= d;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
   endtask

   task automatic send_planned(op_type op, digit_type d);
      planned_items++;
      send_key(op, d);
   endtask

   // filler items; valid digits only when keys_ok
   task automatic send_noise(logic keys_ok);
      int pick;
      pick = $urandom_range(0, 7);
      planned_items++;
      case (pick)
         3, 4: begin
            pick = $urandom_range(0, 3);
            send_key(OP_DIGIT, (pick == 0) ? '0 : digit_type'(DIGIT_MAX + pick));
         end
         5: send_key(OP_UNDEFINED, digit_type'($urandom));
         6: send_key(keys_ok ? OP_DIGIT : OP_TICK, rand_key());
         7: send_key(OP_CHANGE, digit_type'($urandom));
         default: send_key(OP_TICK, digit_type'($urandom));
      endcase
   endtask

   task automatic enter_code(digit_type [CODE_DIGITS-1:0] entry);
      for (int i = 0; i < CODE_DIGITS; i++) begin
         if ($urandom_range(0, 5) == 0)
            send_noise(1'b0);
         send_planned(OP_DIGIT, entry[i]);
      end
   endtask

   // lets the monitor's view settle after the last item
   task automatic sync_state();
      req_chan.valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic drain();
      sync_state();
      while (pending != 0)
         @(posedge clock);
   endtask

   task automatic write_relock_limit(time_type value);
      drain();
      csr_we          <= 1'b1;
      csr_wdata       <= value;
      relock_limit_set = value;
      @(posedge clock);
      csr_we          <= 1'b0;
   endtask

   // one short sequence chosen from the current lock state
   task automatic run_episode();
      digit_type [CODE_DIGITS-1:0] entry;
      digit_type [CODE_DIGITS-1:0] repeat_entry;
      int pick;
      int n;
      int slip;
      entry = code_now;
      pick  = $urandom_range(0, 9);
      slip  = $urandom_range(0, CODE_DIGITS - 1);
      case (mode_now)
         MODE_LOCKED: begin
            if (pick < 6) begin
               // right code, sometimes after stray keys or a change request
               repeat ($urandom_range(0, 3)) send_noise(1'b1);
               if ($urandom_range(0, 2) == 0)
                  send_planned(OP_CHANGE, rand_key());
               enter_code(entry);
            end else if (pick < 8) begin
               // near miss
               entry[slip] = (entry[slip] == DIGIT_MAX) ? DIGIT_MIN : entry[slip] + 1'b1;
               enter_code(entry);
            end else begin
               repeat ($urandom_range(3, 8)) send_noise(1'b1);
               if (pick == 9)
                  send_planned(OP_CHANGE, rand_key());
            end
         end
         MODE_UNLOCKED: begin
            if (pick >= 6)
               n = $urandom_range(0, 2);
            else if (relock_limit_set > 20)
               n = $urandom_range(1, 24);
            else
               n = $urandom_range(1, relock_limit_set + 2);
            repeat (n) begin
               if ($urandom_range(0, 4) == 0)
                  send_noise(1'b1);
               else
                  send_planned(OP_TICK, digit_type'($urandom));
            end
            if (pick >= 6)
               send_planned(OP_CHANGE, rand_key());
         end
         default: begin
            for (int i = 0; i < CODE_DIGITS; i++)
               entry[i] = rand_key();
            repeat_entry = entry;
            if (pick < 5) begin
               enter_code(entry);
               enter_code(repeat_entry);
            end else if (pick < 8) begin
               repeat_entry[slip] = (entry[slip] == DIGIT_MIN) ? DIGIT_MAX
                                                               : entry[slip] - 1'b1;
               enter_code(entry);
               enter_code(repeat_entry);
            end else begin
               repeat ($urandom_range(1, 5)) send_planned(OP_DIGIT, rand_key());
            end
         end
      endcase
      sync_state();
   endtask

   initial begin
      int target;
      req_chan.valid     = 1'b0;
      req_chan.operation = OP_TICK;
      req_chan.digit     = '0;
      rsp_chan.ready     = 1'b0;
      csr_we             = 1'b0;
      csr_wdata          = '0;
      send_idle          = 30;
      recv_idle          = 83;
      relock_limit_set   = RELOCK_LIMIT_RESET;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: stray items, factory unlock, timeout, change on unlock
      write_relock_limit(16'd2);
      send_key(OP_UNDEFINED, 3'd7);
      send_key(OP_TICK, '0);
      send_key(OP_DIGIT, '0);
      send_key(OP_DIGIT, 3'd7);
      for (int i = 0; i < CODE_DIGITS; i++)
         send_key(OP_DIGIT, SHIPPED_CODE[2'(i % FACTORY_LEN)]);
      send_key(OP_DIGIT, DIGIT_MAX);
      repeat (3) send_key(OP_TICK, '0);
      send_key(OP_CHANGE, '0);
      for (int i = 0; i < CODE_DIGITS; i++)
         send_key(OP_DIGIT, SHIPPED_CODE[2'(i % FACTORY_LEN)]);
      repeat (2) begin
         for (int i = 0; i < CODE_DIGITS; i++)
            send_key(OP_DIGIT, digit_type'(DIGIT_MAX - i % FACTORY_LEN));
      end

      // random: three stall regimes, two relock limits each
      for (int seg = 0; seg < 6; seg++) begin
         case (seg / 2)
            0: begin
               send_idle = 30;
               recv_idle = 83;
            end
            1: begin
               send_idle = 83;
               recv_idle = 30;
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
            end
         endcase
         write_relock_limit((seg == 4) ? time_type'($urandom_range(2, 15))
                                       : SEGMENT_RELOCK_LIMIT[seg]);
         target = planned_items + SEGMENT_ITEMS;
         while (planned_items < target)
            run_episode();
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d random key items and %0d results under three stall patterns",
               planned_items, result_count);
      $display("Events seen: %0d unlocks, %0d timeout relocks, %0d code changes, %0d mismatches",
               unlock_count, relock_count, changed_count, mismatch_count);
      if (fail_count == 0)
         $display("** keypad_combination_lock_fsm_core: PASSED **");
      else
         $display("** keypad_combination_lock_fsm_core: FAILED **");
      $finish;
   end

endmodule
